// ----- rtl/swseq_pkg.sv -----
// Shared types and constants for the two-level sheet waveform sequencer.
// Used by swseq_cfg, swseq_step and the top level; depends on nothing else.

package swseq_pkg;

    // Default values of the module parameters.
    localparam int MIN_GAP_TICKS_DEF = 10;
    localparam int TIME_BITS_DEF     = 32;
    localparam int LEVEL_BITS_DEF    = 16;

    // Register file indexes on the configuration port.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUTY       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLANK      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_INT    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_INT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_FREQ   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_FREQ  = 3'd6;

    // Reset values of the registers.
    localparam logic [31:0] PERIOD_RESET = 32'd1000;
    localparam logic [16:0] DUTY_RESET   = 17'd32768;
    localparam logic [16:0] DUTY_ONE     = 17'd65536;
    localparam logic [31:0] HI_RESET     = 32'((64'(PERIOD_RESET) * 64'(DUTY_RESET)) >> 16);

    // Event sequence position, one-hot. The meaning of the step states depends on
    // the blanking mode; the last two are shared by all modes.
    typedef enum logic [7:0] {
        EV_STEP1  = 8'b0000_0001,
        EV_STEP2  = 8'b0000_0010,
        EV_STEP3  = 8'b0000_0100,
        EV_STEP4  = 8'b0000_1000,
        EV_STEP5  = 8'b0001_0000,
        EV_STEP6  = 8'b0010_0000,
        EV_OFF    = 8'b0100_0000,
        EV_HALTED = 8'b1000_0000
    } ev_t;

    // Timing and level values derived from the register file.
    typedef struct packed {
        logic [31:0] period;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] blank;
        logic [31:0] half1;
        logic [31:0] half2;
        logic        hi_short;
        logic        lo_short;
        logic        blank_zero;
        logic        blank_gap;
        logic [15:0] low_int;
        logic [15:0] high_int;
        logic [15:0] low_freq;
        logic [15:0] high_freq;
    } timing_t;

    // One result item.
    typedef struct packed {
        logic        sv;
        logic        sw;
        logic [15:0] iv;
        logic        iw;
        logic [15:0] fv;
        logic        fw;
    } res_t;

    localparam int RES_BITS   = $bits(res_t);
    localparam int TDATA_OUT  = ((RES_BITS + 7) / 8) * 8;

endpackage

// ----- rtl/swseq_cfg.sv -----
// Configuration register file and the derived phase timing.
// Depends on swseq_pkg.

module swseq_cfg #(
    parameter int MIN_GAP_TICKS = swseq_pkg::MIN_GAP_TICKS_DEF,
    parameter int LEVEL_BITS    = swseq_pkg::LEVEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [swseq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [31:0]                          cfg_data,
    output swseq_pkg::timing_t                   timing
);
    import swseq_pkg::*;

    localparam logic [15:0] LVL_MASK = 16'((64'(1) << LEVEL_BITS) - 64'(1));

    logic [31:0] period_reg;
    logic [16:0] duty_reg;
    logic [31:0] blank_reg;
    logic [15:0] low_int_reg;
    logic [15:0] high_int_reg;
    logic [15:0] low_freq_reg;
    logic [15:0] high_freq_reg;
    logic [31:0] hi_reg;
    logic [31:0] hi_next;
    logic [16:0] duty_clamped;
    logic [48:0] product;
    logic [32:0] need;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            duty_reg      <= DUTY_RESET;
            blank_reg     <= '0;
            low_int_reg   <= '0;
            high_int_reg  <= '0;
            low_freq_reg  <= '0;
            high_freq_reg <= '0;
            hi_reg        <= HI_RESET;
        end
        else
        begin
            hi_reg <= hi_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PERIOD:    period_reg    <= cfg_data;
                    REG_DUTY:      duty_reg      <= cfg_data[16:0];
                    REG_BLANK:     blank_reg     <= cfg_data;
                    REG_LOW_INT:   low_int_reg   <= cfg_data[15:0];
                    REG_HIGH_INT:  high_int_reg  <= cfg_data[15:0];
                    REG_LOW_FREQ:  low_freq_reg  <= cfg_data[15:0];
                    REG_HIGH_FREQ: high_freq_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end
        end
    end

    // High phase length; the product is registered so that the step logic sees
    // only the subtractions and compares below.
    always_comb
    begin
        duty_clamped = (duty_reg > DUTY_ONE) ? DUTY_ONE : duty_reg;
        product      = 49'(period_reg) * 49'(duty_clamped);
        hi_next      = product[47:16];
    end

    always_comb
    begin
        need              = {1'b0, blank_reg} + 33'(MIN_GAP_TICKS);
        timing.period     = period_reg;
        timing.hi         = hi_reg;
        timing.lo         = period_reg - hi_reg;
        timing.blank      = blank_reg;
        timing.half1      = {1'b0, blank_reg[31:1]};
        timing.half2      = blank_reg - {1'b0, blank_reg[31:1]};
        timing.hi_short   = {1'b0, hi_reg} < need;
        timing.lo_short   = {1'b0, period_reg - hi_reg} < need;
        timing.blank_zero = (blank_reg == '0);
        timing.blank_gap  = ({1'b0, blank_reg} == 33'(MIN_GAP_TICKS));
        timing.low_int    = low_int_reg & LVL_MASK;
        timing.high_int   = high_int_reg & LVL_MASK;
        timing.low_freq   = low_freq_reg & LVL_MASK;
        timing.high_freq  = high_freq_reg & LVL_MASK;
    end

endmodule

// ----- rtl/swseq_step.sv -----
// Event sequencer state and the one-step transition logic.
// Depends on swseq_pkg and the timing produced by swseq_cfg.

module swseq_step #(
    parameter int TIME_BITS = swseq_pkg::TIME_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               func,
    input  logic [31:0]        now_ticks,
    input  swseq_pkg::timing_t timing,
    output swseq_pkg::res_t    result
);
    import swseq_pkg::*;

    localparam int XW = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [1:0] {
        LVL_NONE,
        LVL_LOW,
        LVL_HIGH
    } lvl_t;

    ev_t                  ev_reg;
    ev_t                  ev_next;
    logic [TIME_BITS-1:0] due_reg;
    logic [TIME_BITS-1:0] due_next;
    logic                 en_reg;
    logic                 en_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] since_due;
    logic                 reached;
    logic [TIME_BITS-1:0] d_hi;
    logic [TIME_BITS-1:0] d_lo;
    logic [TIME_BITS-1:0] d_period;
    logic [TIME_BITS-1:0] d_blank;
    logic [TIME_BITS-1:0] d_half1;
    logic [TIME_BITS-1:0] d_half2;
    logic [TIME_BITS-1:0] delay;
    logic                 advance;
    logic                 blank_out;
    lvl_t                 lvl;

    function automatic logic [TIME_BITS-1:0] to_time(input logic [31:0] x);
        logic [XW-1:0] w;
        w = XW'(x);
        return w[TIME_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg  <= EV_STEP1;
            due_reg <= '0;
            en_reg  <= 1'b1;
        end
        else
        begin
            ev_reg  <= ev_next;
            due_reg <= due_next;
            en_reg  <= en_next;
        end
    end

    always_comb
    begin
        now_t     = to_time(now_ticks);
        since_due = now_t - due_reg;
        reached   = !since_due[TIME_BITS-1];
        d_hi      = to_time(timing.hi);
        d_lo      = to_time(timing.lo);
        d_period  = to_time(timing.period);
        d_blank   = to_time(timing.blank);
        d_half1   = to_time(timing.half1);
        d_half2   = to_time(timing.half2);
    end

    always_comb
    begin
        ev_next   = ev_reg;
        due_next  = due_reg;
        en_next   = en_reg;
        delay     = '0;
        advance   = 1'b0;
        blank_out = 1'b0;
        lvl       = LVL_NONE;
        result    = '0;

        if (fire)
        begin
            if (func)
            begin
                if (en_reg)
                begin
                    en_next = 1'b0;
                    ev_next = EV_OFF;
                end
                else
                begin
                    en_next  = 1'b1;
                    due_next = now_t;
                    ev_next  = EV_STEP1;
                end
            end
            else if (reached && ev_reg != EV_HALTED)
            begin
                if (ev_reg == EV_OFF)
                begin
                    blank_out = 1'b1;
                    ev_next   = EV_HALTED;
                end
                else if (timing.blank_zero)
                begin
                    case (ev_reg)
                        EV_STEP1:
                        begin
                            lvl = LVL_HIGH; delay = d_hi; advance = 1'b1; ev_next = EV_STEP2;
                        end
                        EV_STEP2:
                        begin
                            lvl = LVL_LOW; delay = d_lo; advance = 1'b1; ev_next = EV_STEP1;
                        end
                        default: ;
                    endcase
                end
                else if (timing.blank_gap)
                begin
                    // Short blank: the frequency is retuned while the switch is off.
                    case (ev_reg)
                        EV_STEP1:
                        begin
                            advance = 1'b1;
                            if (timing.hi_short)
                            begin
                                lvl = LVL_LOW; delay = d_period;
                            end
                            else
                            begin
                                blank_out = 1'b1;
                                result.fw = 1'b1;
                                result.fv = timing.high_freq;
                                delay     = d_blank;
                                ev_next   = EV_STEP2;
                            end
                        end
                        EV_STEP2:
                        begin
                            lvl = LVL_HIGH; delay = d_hi - d_blank; advance = 1'b1;
                            ev_next = EV_STEP3;
                        end
                        EV_STEP3:
                        begin
                            advance = 1'b1;
                            if (timing.lo_short)
                            begin
                                lvl = LVL_HIGH; delay = d_period;
                            end
                            else
                            begin
                                blank_out = 1'b1;
                                result.fw = 1'b1;
                                result.fv = timing.low_freq;
                                delay     = d_blank;
                                ev_next   = EV_STEP4;
                            end
                        end
                        EV_STEP4:
                        begin
                            lvl = LVL_LOW; delay = d_lo - d_blank; advance = 1'b1;
                            ev_next = EV_STEP1;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    // Long blank split in two halves around the retune.
                    case (ev_reg)
                        EV_STEP1:
                        begin
                            advance = 1'b1;
                            if (timing.hi_short)
                            begin
                                lvl = LVL_LOW; delay = d_period;
                            end
                            else
                            begin
                                blank_out = 1'b1; delay = d_half1; ev_next = EV_STEP2;
                            end
                        end
                        EV_STEP2:
                        begin
                            result.fw = 1'b1;
                            result.fv = timing.high_freq;
                            delay = d_half2; advance = 1'b1; ev_next = EV_STEP3;
                        end
                        EV_STEP3:
                        begin
                            lvl = LVL_HIGH; delay = d_hi - d_blank; advance = 1'b1;
                            ev_next = EV_STEP4;
                        end
                        EV_STEP4:
                        begin
                            advance = 1'b1;
                            if (timing.lo_short)
                            begin
                                lvl = LVL_HIGH; delay = d_period;
                            end
                            else
                            begin
                                blank_out = 1'b1; delay = d_half1; ev_next = EV_STEP5;
                            end
                        end
                        EV_STEP5:
                        begin
                            result.fw = 1'b1;
                            result.fv = timing.low_freq;
                            delay = d_half2; advance = 1'b1; ev_next = EV_STEP6;
                        end
                        EV_STEP6:
                        begin
                            lvl = LVL_LOW; delay = d_lo - d_blank; advance = 1'b1;
                            ev_next = EV_STEP1;
                        end
                        default: ;
                    endcase
                end

                if (advance)
                begin
                    due_next = due_reg + delay;
                end

                if (blank_out)
                begin
                    result.sw = 1'b1;
                    result.sv = 1'b0;
                    result.iw = 1'b1;
                    result.iv = '0;
                end

                case (lvl)
                    LVL_LOW:
                    begin
                        result.fw = 1'b1; result.fv = timing.low_freq;
                        result.iw = 1'b1; result.iv = timing.low_int;
                        result.sw = 1'b1; result.sv = 1'b1;
                    end
                    LVL_HIGH:
                    begin
                        result.fw = 1'b1; result.fv = timing.high_freq;
                        result.iw = 1'b1; result.iv = timing.high_int;
                        result.sw = 1'b1; result.sv = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/two_level_sheet_waveform_sequencer_core.sv -----
// An accepted item waits in the input register until the step fires; its result item
// then waits in the result register. One item per cycle is taken while m_tready is high.
// A write reaches the high-phase length through its register, then the registered multiply.
// Reset (rst_n, asynchronous, active low) empties both pipeline registers, loads the
// register defaults and puts the sequencer at its first event with the sheet on.
// Depends on swseq_pkg, swseq_cfg and swseq_step.

module two_level_sheet_waveform_sequencer_core #(
    parameter int MIN_GAP_TICKS = swseq_pkg::MIN_GAP_TICKS_DEF,
    parameter int TIME_BITS     = swseq_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS    = swseq_pkg::LEVEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // now_ticks
    input  logic [0:0]                          s_tuser,   // func
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // freq_write, freq_value[16], intensity_write, intensity_value[16],
    // switch_write, switch_level, then zero fill
    output logic [swseq_pkg::TDATA_OUT-1:0]     m_tdata,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [swseq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [31:0]                         cfg_data
);
    import swseq_pkg::*;

    // Input register: holds one accepted item until the step logic takes it.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_func_reg;
    logic [31:0] in_now_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        out_data_reg;

    logic        s_accept;
    logic        out_free;
    logic        fire;
    timing_t     timing;
    res_t        step_result;

    // The step fires whenever an item waits and the result register can take a
    // new value, either because it is empty or because its item leaves now.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    swseq_cfg #(
        .MIN_GAP_TICKS (MIN_GAP_TICKS),
        .LEVEL_BITS    (LEVEL_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    swseq_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .func      (in_func_reg),
        .now_ticks (in_now_reg),
        .timing    (timing),
        .result    (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg <= s_tuser[0];
            in_now_reg  <= s_tdata;
        end
        if (fire)
        begin
            out_data_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT'(out_data_reg);

    // Every step that fires leaves a result waiting in the next cycle.
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("step fired without a result item");

    // A waiting input item is neither lost nor overwritten while the output stalls.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_now_reg)
            && $stable(in_func_reg)))
        else $error("pending input item changed during a stall");

    // Switching off always comes with the intensity written to zero.
    a_blank_zero_intensity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.sw && !out_data_reg.sv)
            |-> (out_data_reg.iw && out_data_reg.iv == '0))
        else $error("switch off without intensity blanked");

    // A value without its write strobe is reported as zero.
    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.fw || out_data_reg.fv == '0)
            && (out_data_reg.iw || out_data_reg.iv == '0)
            && (out_data_reg.sw || !out_data_reg.sv)))
        else $error("value present without its write strobe");

endmodule

// ----- sim/swseq_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the two-level sheet waveform sequencer: watches the item channels and
// the configuration port, predicts every result item and compares it. Depends on swseq_pkg.

module swseq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // now_ticks
    input  logic [0:0]                          s_tuser,   // func
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // freq_write, freq_value[16], intensity_write, intensity_value[16],
    // switch_write, switch_level, then zero fill
    input  logic [swseq_pkg::TDATA_OUT-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [swseq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [31:0]                         cfg_data,
    output int                                  fail_count,
    output int                                  outstanding
);
    import swseq_pkg::*;

    localparam logic        FUNC_TOGGLE = 1'b1;
    localparam logic [63:0] MIN_GAP     = 64'(MIN_GAP_TICKS_DEF);
    localparam int          SHOW_LIMIT  = 10;

    // Sequence positions; the meaning of steps one to six depends on the blanking mode.
    localparam logic [3:0] SEQ_1      = 4'd1;
    localparam logic [3:0] SEQ_2      = 4'd2;
    localparam logic [3:0] SEQ_3      = 4'd3;
    localparam logic [3:0] SEQ_4      = 4'd4;
    localparam logic [3:0] SEQ_5      = 4'd5;
    localparam logic [3:0] SEQ_6      = 4'd6;
    localparam logic [3:0] SEQ_OFF    = 4'd7;
    localparam logic [3:0] SEQ_HALTED = 4'd8;

    localparam int LEVELS_NONE = 0;
    localparam int LEVELS_LOW  = 1;
    localparam int LEVELS_HIGH = 2;

    logic [31:0] period_r;
    logic [16:0] duty_r;
    logic [31:0] blank_r;
    logic [15:0] lo_int, hi_int, lo_freq, hi_freq;

    logic [3:0]  seq_pos;
    logic [31:0] due_at;
    logic        sheet_on;

    res_t        awaited_writes[$];
    int          errors;

    function automatic res_t blanked();
        res_t r;
        r = '0;
        r.sw = 1'b1;
        r.iw = 1'b1;
        return r;
    endfunction

    // One step of the sequencer: updates the shadow state and returns the strobes.
    function automatic res_t sequencer_step(input logic flip, input logic [31:0] now);
        res_t        r;
        logic [31:0] elapsed;
        logic [63:0] duty, hi, lo, need;
        logic [31:0] half1, half2;
        int          levels;
        r = '0;
        levels = LEVELS_NONE;
        elapsed = now - due_at;
        if (flip == FUNC_TOGGLE)
        begin
            if (sheet_on)
            begin
                sheet_on = 1'b0;
                seq_pos = SEQ_OFF;
            end
            else
            begin
                sheet_on = 1'b1;
                due_at = now;
                seq_pos = SEQ_1;
            end
        end
        else if (!elapsed[31] && seq_pos != SEQ_HALTED)
        begin
            duty = (duty_r > DUTY_ONE) ? 64'(DUTY_ONE) : 64'(duty_r);
            hi = (64'(period_r) * duty) >> 16;
            lo = 64'(period_r) - hi;
            half1 = blank_r >> 1;
            half2 = blank_r - half1;
            need = 64'(blank_r) + MIN_GAP;
            if (seq_pos == SEQ_OFF)
            begin
                r = blanked();
                seq_pos = SEQ_HALTED;
            end
            else if (blank_r == 32'd0)
            begin
                case (seq_pos)
                    SEQ_1:
                    begin
                        levels = LEVELS_HIGH;
                        due_at = due_at + hi[31:0];
                        seq_pos = SEQ_2;
                    end
                    SEQ_2:
                    begin
                        levels = LEVELS_LOW;
                        due_at = due_at + lo[31:0];
                        seq_pos = SEQ_1;
                    end
                    default: ;
                endcase
            end
            else if (64'(blank_r) == MIN_GAP)
            begin
                // Short blank: the retune happens together with the blank.
                case (seq_pos)
                    SEQ_1:
                    begin
                        if (hi < need)
                        begin
                            levels = LEVELS_LOW;
                            due_at = due_at + 32'(lo + hi);
                        end
                        else
                        begin
                            r = blanked();
                            r.fw = 1'b1;
                            r.fv = hi_freq;
                            due_at = due_at + blank_r;
                            seq_pos = SEQ_2;
                        end
                    end
                    SEQ_2:
                    begin
                        levels = LEVELS_HIGH;
                        due_at = due_at + 32'(hi - 64'(blank_r));
                        seq_pos = SEQ_3;
                    end
                    SEQ_3:
                    begin
                        if (lo < need)
                        begin
                            levels = LEVELS_HIGH;
                            due_at = due_at + 32'(lo + hi);
                        end
                        else
                        begin
                            r = blanked();
                            r.fw = 1'b1;
                            r.fv = lo_freq;
                            due_at = due_at + blank_r;
                            seq_pos = SEQ_4;
                        end
                    end
                    SEQ_4:
                    begin
                        levels = LEVELS_LOW;
                        due_at = due_at + 32'(lo - 64'(blank_r));
                        seq_pos = SEQ_1;
                    end
                    default: ;
                endcase
            end
            else
            begin
                // Long blank in two halves with the retune in the middle.
                case (seq_pos)
                    SEQ_1:
                    begin
                        if (hi < need)
                        begin
                            levels = LEVELS_LOW;
                            due_at = due_at + 32'(lo + hi);
                        end
                        else
                        begin
                            r = blanked();
                            due_at = due_at + half1;
                            seq_pos = SEQ_2;
                        end
                    end
                    SEQ_2:
                    begin
                        r.fw = 1'b1;
                        r.fv = hi_freq;
                        due_at = due_at + half2;
                        seq_pos = SEQ_3;
                    end
                    SEQ_3:
                    begin
                        levels = LEVELS_HIGH;
                        due_at = due_at + 32'(hi - 64'(blank_r));
                        seq_pos = SEQ_4;
                    end
                    SEQ_4:
                    begin
                        if (lo < need)
                        begin
                            levels = LEVELS_HIGH;
                            due_at = due_at + 32'(lo + hi);
                        end
                        else
                        begin
                            r = blanked();
                            due_at = due_at + half1;
                            seq_pos = SEQ_5;
                        end
                    end
                    SEQ_5:
                    begin
                        r.fw = 1'b1;
                        r.fv = lo_freq;
                        due_at = due_at + half2;
                        seq_pos = SEQ_6;
                    end
                    SEQ_6:
                    begin
                        levels = LEVELS_LOW;
                        due_at = due_at + 32'(lo - 64'(blank_r));
                        seq_pos = SEQ_1;
                    end
                    default: ;
                endcase
            end
            if (levels == LEVELS_LOW)
            begin
                r.fw = 1'b1;
                r.fv = lo_freq;
                r.iw = 1'b1;
                r.iv = lo_int;
                r.sw = 1'b1;
                r.sv = 1'b1;
            end
            else if (levels == LEVELS_HIGH)
            begin
                r.fw = 1'b1;
                r.fv = hi_freq;
                r.iw = 1'b1;
                r.iv = hi_int;
                r.sw = 1'b1;
                r.sv = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        res_t want, got;
        if (!rst_n)
        begin
            period_r = PERIOD_RESET;
            duty_r   = DUTY_RESET;
            blank_r  = '0;
            lo_int   = '0;
            hi_int   = '0;
            lo_freq  = '0;
            hi_freq  = '0;
            seq_pos  = SEQ_1;
            due_at   = '0;
            sheet_on = 1'b1;
            awaited_writes.delete();
            errors = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PERIOD:    period_r = cfg_data;
                    REG_DUTY:      duty_r   = cfg_data[16:0];
                    REG_BLANK:     blank_r  = cfg_data;
                    REG_LOW_INT:   lo_int   = cfg_data[15:0];
                    REG_HIGH_INT:  hi_int   = cfg_data[15:0];
                    REG_LOW_FREQ:  lo_freq  = cfg_data[15:0];
                    REG_HIGH_FREQ: hi_freq  = cfg_data[15:0];
                    default: ;
                endcase
            end
            // Results leave before new items are predicted; an item is registered first.
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata[RES_BITS-1:0]);
                if (awaited_writes.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("%0t: result item with none expected, got %0h",
                                 $realtime, m_tdata);
                end
                else
                begin
                    want = awaited_writes.pop_front();
                    check_field("freq_write", 32'(want.fw), 32'(got.fw));
                    check_field("freq_value", 32'(want.fv), 32'(got.fv));
                    check_field("intensity_write", 32'(want.iw), 32'(got.iw));
                    check_field("intensity_value", 32'(want.iv), 32'(got.iv));
                    check_field("switch_write", 32'(want.sw), 32'(got.sw));
                    check_field("switch_level", 32'(want.sv), 32'(got.sv));
                    check_field("zero fill", 32'd0, 32'(m_tdata >> RES_BITS));
                end
            end
            if (s_tvalid && s_tready)
                awaited_writes.push_back(sequencer_step(s_tuser[0], s_tdata));
            outstanding <= awaited_writes.size();
            fail_count  <= errors;
        end
    end

endmodule

// ----- sim/two_level_sheet_waveform_sequencer_core_tb.sv -----
`timescale 1ns / 100ps
// Top of the sequencer testbench: clock, reset, configuration phases and item traffic.
// Depends on swseq_pkg, the sequencer core and swseq_checker, which does all checking.

module two_level_sheet_waveform_sequencer_core_tb;
    import swseq_pkg::*;

    localparam int          ITEM_TARGET = 1550;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [31:0] GAP_TICKS   = 32'(MIN_GAP_TICKS_DEF);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [TDATA_OUT-1:0] m_tdata;
    logic        cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0] cfg_data;

    int          fail_count;
    int          outstanding;

    // Shared between the stimulus and the result sink.
    bit          quiet_phase;     // neither side idles while set
    bit          hold_request;    // asks the sink for one long hold-off
    bit          sheet_on = 1'b1; // every toggle flips the sheet, so the top can track it
    logic [31:0] clock_now;       // running time base for well-formed traffic
    int          items_sent;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    two_level_sheet_waveform_sequencer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    swseq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Result sink. Before each result item it waits a random number of cycles, except
    // in quiet phases. When the stimulus asks for it, it holds off once for a long
    // stretch so that the output register fills and the input side stalls.
    initial
    begin : result_sink
        int pause;
        m_tready <= 1'b0;
        wait (rst_n == 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pause = quiet_phase ? 0 : $urandom_range(0, 10);
                if (pause > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (pause) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Offers one item after a random gap and returns at the edge where it is taken.
    // The valid is only lowered when there is a gap, so it never drops and rises
    // within one time step.
    task automatic send_item(input bit flip_sheet, input logic [31:0] now);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= now;
        s_tuser  <= flip_sheet;
        do
            @(posedge clk);
        while (!s_tready);
        if (flip_sheet)
            sheet_on = !sheet_on;
        items_sent++;
    endtask

    // Waits until every predicted result item has come back, then lets the
    // block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes the whole register file. The high-phase length is derived through a
    // registered multiply, so the task waits before traffic resumes.
    task automatic configure(input logic [31:0] period, input logic [31:0] duty,
                             input logic [31:0] blank, input logic [15:0] li,
                             input logic [15:0] hi, input logic [15:0] lf,
                             input logic [15:0] hf);
        write_reg(REG_PERIOD, period);
        write_reg(REG_DUTY, duty);
        write_reg(REG_BLANK, blank);
        write_reg(REG_LOW_INT, 32'(li));
        write_reg(REG_HIGH_INT, 32'(hi));
        write_reg(REG_LOW_FREQ, 32'(lf));
        write_reg(REG_HIGH_FREQ, 32'(hf));
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // One configuration phase. With resync the sheet is switched off, blanked once
    // and switched back on at the current time, so that the due time follows the
    // time base. Without it, a position left over from the previous mode stays in
    // place until the next toggle, which is a case worth seeing too. Most items are
    // a time base moving forward in steps scaled to the period; some are toggles and
    // some carry a random time anywhere in the 32-bit range.
    task automatic run_phase(input logic [31:0] period, input logic [31:0] duty,
                             input logic [31:0] blank, input int n_items,
                             input bit resync, input bit squeeze);
        int unsigned step_max;
        int          roll;
        settle();
        configure(period, duty, blank, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        if (resync)
        begin
            if (sheet_on)
            begin
                send_item(1'b1, clock_now);
                send_item(1'b0, clock_now);
            end
            send_item(1'b1, clock_now);
        end
        if (squeeze)
            hold_request = 1'b1;
        if (period <= 32'd4096)
            step_max = period / 2 + ((blank > 32'd64) ? 64 : blank) + 2;
        else
            step_max = period >> $urandom_range(2, 6);
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3 || (!sheet_on && roll < 25))
                send_item(1'b1, clock_now);
            else if (roll >= 90)
                send_item(1'b0, $urandom);
            else
            begin
                clock_now = clock_now + $urandom_range(0, step_max);
                send_item(1'b0, clock_now);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] period, duty, blank;
        int          phase;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_PERIOD;
        cfg_data  <= '0;
        items_sent = 0;
        quiet_phase = 1'b0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk on the reset settings: period 1000, half duty, no blanking.
        // It covers the due-time boundary both ways, a toggle off with its single
        // blank, an update while halted, a toggle on, and a due time that wraps.
        send_item(1'b0, 32'd0);                      // due: high set, next at 500
        send_item(1'b0, 32'd499);                    // not yet due
        send_item(1'b0, 32'd500);                    // low set, next at 1000
        send_item(1'b0, 32'd1000 + 32'h8000_0000);   // half a wrap ahead counts as early
        send_item(1'b0, 32'd1000 + 32'h7FFF_FFFF);   // just inside: due
        send_item(1'b1, 32'd0);                      // sheet off
        send_item(1'b0, 32'd1499);                   // not yet due
        send_item(1'b0, 32'd1500);                   // the single blank, then halted
        send_item(1'b0, 32'd2000);                   // halted: nothing written
        send_item(1'b1, 32'hFFFF_FFF0);              // sheet on, due now
        send_item(1'b0, 32'hFFFF_FFF0);              // high set, due time wraps past zero
        send_item(1'b0, 32'h0000_0010);              // before the wrapped due time
        send_item(1'b0, 32'h0000_01E4);              // low set
        clock_now = 32'h0000_0200;

        // Extremes of the registers and the corners of the blanking modes.
        run_phase(32'd0, 32'd0, 32'd0, 12, 1'b1, 1'b0);                   // zero period
        run_phase(32'hFFFF_FFFF, 32'h1_FFFF, 32'hFFFF_FFFF, 12, 1'b1, 1'b0); // clamped duty
        run_phase(32'd100, 32'(DUTY_ONE), GAP_TICKS, 15, 1'b1, 1'b0);     // low phase too short
        run_phase(32'd100, 32'd0, GAP_TICKS, 15, 1'b1, 1'b0);             // high phase too short
        run_phase(32'd60, 32'd32768, GAP_TICKS, 20, 1'b1, 1'b0);          // short blank both ways
        run_phase(32'd80, 32'd32768, 32'd21, 20, 1'b1, 1'b0);             // long blank, odd halves
        run_phase(32'd90, 32'd40000, 32'd0, 15, 1'b0, 1'b0);              // leftover position
        run_phase(32'd1, 32'd1, 32'd1, 12, 1'b1, 1'b0);

        // Random phases until the item budget is spent.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                7:       period = $urandom_range(301, 100000);
                8:       period = $urandom;
                9:       period = $urandom_range(0, 3);
                default: period = $urandom_range(1, 300);
            endcase
            case ($urandom_range(0, 9))
                8:       duty = 32'(DUTY_ONE);
                9:       duty = $urandom_range(65537, 131071);
                default: duty = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: blank = 32'd0;
                3, 4, 5: blank = GAP_TICKS;
                9:       blank = $urandom;
                default: blank = $urandom_range(1, 60);
            endcase
            quiet_phase = (phase % 4 == 1);
            run_phase(period, duty, blank, $urandom_range(20, 60),
                      $urandom_range(0, 3) != 0, phase == 3);
            phase++;
        end

        settle();
        quiet_phase = 1'b0;
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS two_level_sheet_waveform_sequencer_core");
        else
            $display("FAIL two_level_sheet_waveform_sequencer_core");
        $finish;
    end

    // A correct run needs well under half a millisecond of simulated time.
    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL two_level_sheet_waveform_sequencer_core");
        $finish;
    end

endmodule
